// ----- src/msq_pkg.sv -----
`default_nettype none
package msq_pkg;
    localparam int unsigned CORNERS   = 4;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned MAG_W     = 33;
    // partial remainder: below twice the divisor before each compare
    localparam int unsigned REM_W     = MAG_W + 1;
    // quotient of (an << 16) / ad, at most 2^16 since an <= ad
    localparam int unsigned QUOT_W    = FRAC_BITS + 1;
    localparam int unsigned EDGE_W    = 2;
    localparam logic signed [VALUE_W-1:0] THRESHOLD_RESET = 32'sd65536;
    localparam int unsigned IN_TDATA_W  = 8 * COORD_W + 4 * VALUE_W;
    localparam int unsigned OUT_TDATA_W = 2 * COORD_W + EDGE_W + 6;

    // payload handed from one divider cell to the next
    typedef struct packed {
        logic                      active;   // an edge crossing travels in this slot
        logic [MAG_W-1:0]          den;      // |v_j - v_i|
        logic [REM_W-1:0]          rem;      // partial remainder
        logic [QUOT_W-1:0]         quot;     // quotient bits so far
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W:0]   dx;
        logic signed [COORD_W:0]   dy;
    } t_div;
endpackage
`default_nettype wire

// ----- src/marching_squares_cell_edges_top.sv -----
`default_nettype none
// Path from input request to first point: set-up, 17 divider cells, multiply, add,
// holding stage. Throughput: one point per cycle while m_axis_tready is high; a cell
// with no crossing yields no point, otherwise one point per crossing, four at worst.
// The whole pipeline holds while the holding stage has a point that does not leave.
// Synchronous active-low reset clears all valid flags; threshold = 1.0.
module marching_squares_cell_edges_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // corner0_x, corner0_y, ... corner3_y, value0 .. value3
    input  wire logic [msq_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // point_x, point_y, edge_index, zero pad
    output logic [msq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [msq_pkg::VALUE_W-1:0] i_cfg_data
);
    import msq_pkg::*;

    logic signed [VALUE_W-1:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thr <= THRESHOLD_RESET;
        else if (i_cfg_valid) r_thr <= i_cfg_data;
    end
    assign o_cfg_ready = i_rst_n;

    // pipeline advances only when the result holding stage is free or its last point is leaving
    logic w_en, w_acc;
    logic [3:0] r_pend;
    logic signed [COORD_W-1:0] r_hx [4], r_hy [4];
    logic w_act [4];
    logic signed [COORD_W-1:0] w_x [4], w_y [4];

    assign w_en = (r_pend == 4'd0) || (m_axis_tvalid && m_axis_tready && $countones(r_pend) == 1);
    assign s_axis_tready = w_en && i_rst_n;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            localparam int unsigned J = (g + 1) % 4;
            msq_lane u_lane (
                .i_clk  (i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_acc),
                .i_thr  (r_thr),
                .i_vi   (s_axis_tdata[8*COORD_W + g*VALUE_W +: VALUE_W]),
                .i_vj   (s_axis_tdata[8*COORD_W + J*VALUE_W +: VALUE_W]),
                .i_xi   (s_axis_tdata[(2*g)*COORD_W +: COORD_W]),
                .i_yi   (s_axis_tdata[(2*g+1)*COORD_W +: COORD_W]),
                .i_xj   (s_axis_tdata[(2*J)*COORD_W +: COORD_W]),
                .i_yj   (s_axis_tdata[(2*J+1)*COORD_W +: COORD_W]),
                .o_active(w_act[g]), .o_x(w_x[g]), .o_y(w_y[g])
            );
        end
    endgenerate

    // holding stage: pending mask, points sent lowest edge first
    logic [1:0] w_sel;
    logic [3:0] w_rest;
    always_comb begin
        w_sel = 2'd0;
        for (int k = 3; k >= 0; k--) if (r_pend[k]) w_sel = 2'(k);
        w_rest = r_pend & ~(4'b1 << w_sel);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_en) begin
            r_pend <= {w_act[3], w_act[2], w_act[1], w_act[0]};
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_pend <= w_rest;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_hx[k] <= w_x[k];
                r_hy[k] <= w_y[k];
            end
        end
    end
    assign m_axis_tvalid = r_pend != 4'd0;
    assign m_axis_tlast  = w_rest == 4'd0;
    assign m_axis_tdata  = {6'd0, w_sel, r_hy[w_sel], r_hx[w_sel]};
endmodule
`default_nettype wire

// ----- src/msq_div_cell.sv -----
`default_nettype none
// One restoring-division step per cell, the remainder moves one cell on per cycle while i_en is high
module msq_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire msq_pkg::t_div i_d,
    output msq_pkg::t_div      o_d
);
    import msq_pkg::*;
    t_div r_d, n_d;
    logic [REM_W:0] w_sub;

    // try subtract, take the quotient bit, then shift for the next cell
    always_comb begin
        w_sub = {1'b0, i_d.rem} - {2'b00, i_d.den};
        n_d   = i_d;
        if (!w_sub[REM_W]) begin
            n_d.rem  = {w_sub[REM_W-2:0], 1'b0};
            n_d.quot = {i_d.quot[QUOT_W-2:0], 1'b1};
        end else begin
            n_d.rem  = {i_d.rem[REM_W-2:0], 1'b0};
            n_d.quot = {i_d.quot[QUOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.active <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end
    assign o_d = r_d;
endmodule
`default_nettype wire

// ----- src/msq_lane.sv -----
`default_nettype none
// Per-edge lane: set-up cell, chain of division cells, interpolation stages
module msq_lane (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_valid,
    input  wire logic signed [msq_pkg::VALUE_W-1:0] i_thr,
    input  wire logic signed [msq_pkg::VALUE_W-1:0] i_vi,
    input  wire logic signed [msq_pkg::VALUE_W-1:0] i_vj,
    input  wire logic signed [msq_pkg::COORD_W-1:0] i_xi,
    input  wire logic signed [msq_pkg::COORD_W-1:0] i_yi,
    input  wire logic signed [msq_pkg::COORD_W-1:0] i_xj,
    input  wire logic signed [msq_pkg::COORD_W-1:0] i_yj,
    output logic                                    o_active,
    output logic signed [msq_pkg::COORD_W-1:0]      o_x,
    output logic signed [msq_pkg::COORD_W-1:0]      o_y
);
    import msq_pkg::*;
    localparam int unsigned PROD_W = COORD_W + 1 + QUOT_W + 1;

    t_div w_chain [QUOT_W+1];
    t_div r_setup;
    t_div w_last;
    logic signed [MAG_W-1:0] w_num, w_den;
    logic [MAG_W-1:0] w_an;
    logic w_in_i, w_in_j;
    logic signed [PROD_W-1:0] r_px, r_py;
    logic signed [COORD_W-1:0] r_ax, r_ay;
    logic r_a1;

    // set-up cell: magnitudes and coordinate differences
    always_comb begin
        w_in_i = i_vi >= i_thr;
        w_in_j = i_vj >= i_thr;
        w_num  = MAG_W'(i_thr) - MAG_W'(i_vi);
        w_den  = MAG_W'(i_vj) - MAG_W'(i_vi);
        w_an   = w_num[MAG_W-1] ? -w_num : w_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup.active <= 1'b0;
        end else if (i_en) begin
            r_setup.active <= i_valid && (w_in_i != w_in_j);
            r_setup.den    <= w_den[MAG_W-1] ? -w_den : w_den;
            r_setup.rem    <= {1'b0, w_an};
            r_setup.quot   <= '0;
            r_setup.ax     <= i_xi;
            r_setup.ay     <= i_yi;
            r_setup.dx     <= (COORD_W+1)'(i_xj) - (COORD_W+1)'(i_xi);
            r_setup.dy     <= (COORD_W+1)'(i_yj) - (COORD_W+1)'(i_yi);
        end
    end

    // one quotient bit per cell, most significant first
    assign w_chain[0] = r_setup;
    genvar g;
    generate
        for (g = 0; g < QUOT_W; g++) begin : g_cell
            msq_div_cell u_div (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (i_en),
                .i_d    (w_chain[g]),
                .o_d    (w_chain[g+1])
            );
        end
    endgenerate

    // multiply stage
    assign w_last = w_chain[QUOT_W];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= 1'b0;
        end else if (i_en) begin
            r_a1 <= w_last.active;
            r_px <= PROD_W'(w_last.dx) * $signed({1'b0, w_last.quot});
            r_py <= PROD_W'(w_last.dy) * $signed({1'b0, w_last.quot});
            r_ax <= w_last.ax;
            r_ay <= w_last.ay;
        end
    end

    // floor shift and add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_active <= 1'b0;
        end else if (i_en) begin
            o_active <= r_a1;
            o_x      <= r_ax + COORD_W'(r_px >>> FRAC_BITS);
            o_y      <= r_ay + COORD_W'(r_py >>> FRAC_BITS);
        end
    end
endmodule
`default_nettype wire
